// ----- rtl/imrc_pkg.sv -----
package imrc_pkg;

  // Input modes.
  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_CALC = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;
  localparam logic [1:0] CFG_OUT_SHIFT = 2'd3;

  // Configuration reset values.
  localparam logic [4:0] ROWS_A_RST    = 5'd16;
  localparam logic [4:0] INNER_LEN_RST = 5'd16;
  localparam logic [4:0] COLS_B_RST    = 5'd16;
  localparam logic [4:0] OUT_SHIFT_RST = 5'd8;

  localparam int REG_W = 5;
  localparam int SUM_W = 20;
  // Up to 31 terms of 128 * 255 fit in 21 signed bits.
  localparam int ACC_W = 21;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_empty;
    logic last_issue;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/imrc_ram.sv -----
module imrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/imrc_ctrl.sv -----
module imrc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         mode,
  output logic               in_ready,
  input  imrc_pkg::status_t  status,
  output imrc_pkg::cmd_t     cmd
);

  import imrc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode)
            MODE_WR_A: cmd.wr_a = 1'b1;
            MODE_WR_B: cmd.wr_b = 1'b1;
            MODE_CALC: begin
              cmd.start = 1'b1;
              // Nothing to read for a bad request or an empty sum.
              if (status.req_bad || status.req_empty) begin
                state_next = ST_DRAIN;
              end else begin
                state_next = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/imrc_dp.sv -----
module imrc_dp #(
  parameter int DIM = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  imrc_pkg::cmd_t              cmd,
  output imrc_pkg::status_t           status,
  input  logic [3:0]                  row,
  input  logic [3:0]                  col,
  input  logic [7:0]                  elem_value,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [imrc_pkg::REG_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic signed [imrc_pkg::SUM_W-1:0] dot_sum,
  output logic                        range_error
);

  import imrc_pkg::*;

  localparam int DEPTH = DIM * DIM;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  function automatic logic [6:0] cap_dim(input logic [REG_W-1:0] v);
    logic [6:0] r;
    r = (7'(v) > 7'(DIM)) ? 7'(DIM) : 7'(v);
    return r;
  endfunction

  logic [REG_W-1:0] rows_a;
  logic [REG_W-1:0] inner_len;
  logic [REG_W-1:0] cols_b;
  logic [REG_W-1:0] out_shift;

  logic [3:0]       req_row;
  logic [3:0]       req_col;
  logic [REG_W-1:0] term_cnt;
  logic [REG_W-1:0] term_idx;
  logic             req_err;
  logic             rd_valid;
  logic signed [ACC_W-1:0] acc;

  logic [REG_W-1:0] n_cap;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    a_raddr;
  logic [AW-1:0]    b_raddr;
  logic [7:0]       a_rdata;
  logic [7:0]       b_rdata;
  logic signed [16:0] prod;
  logic [ACC_W-1:0] shifted;
  logic [7:0]       byte_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= ROWS_A_RST;
      inner_len <= INNER_LEN_RST;
      cols_b    <= COLS_B_RST;
      out_shift <= OUT_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_INNER_LEN: inner_len <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        CFG_OUT_SHIFT: out_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request checks on the word at the input.
  assign n_cap = REG_W'(cap_dim(inner_len));
  assign status.req_bad = (7'(row) >= cap_dim(rows_a)) || (7'(col) >= cap_dim(cols_b));
  assign status.req_empty = (n_cap == '0);
  assign status.last_issue = (term_idx == term_cnt - 1'b1);
  assign status.out_free = !out_valid || out_ready;

  assign wr_ok   = (7'(row) < 7'(DIM)) && (7'(col) < 7'(DIM));
  assign wr_addr = AW'(int'(row) * DIM + int'(col));
  assign a_raddr = AW'(int'(req_row) * DIM + int'(term_idx));
  assign b_raddr = AW'(int'(term_idx) * DIM + int'(req_col));

  imrc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a && wr_ok),
    .waddr (wr_addr),
    .wdata (elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imrc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b && wr_ok),
    .waddr (wr_addr),
    .wdata (elem_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  // A is signed, B is unsigned: B gets a zero sign bit.
  assign prod = $signed(a_rdata) * $signed({1'b0, b_rdata});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_row  <= row;
      req_col  <= col;
      term_cnt <= n_cap;
      req_err  <= status.req_bad;
      term_idx <= '0;
      acc      <= '0;
    end else begin
      if (cmd.issue) begin
        term_idx <= term_idx + 1'b1;
      end
      if (rd_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign shifted = ACC_W'(acc >>> out_shift);

  always_comb begin
    if (req_err || acc <= 0) begin
      byte_val = '0;
    end else if (shifted > ACC_W'(BYTE_MAX)) begin
      byte_val = BYTE_MAX;
    end else begin
      byte_val = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_byte    <= byte_val;
      dot_sum     <= req_err ? '0 : acc[SUM_W-1:0];
      range_error <= req_err;
    end
  end

endmodule

// ----- rtl/int8_matmul_requant_clamp_unit.sv -----
// Matrix element writes (modes 0 and 1) leave the unit idle and ready for the next word.
// A result request reads each term of the capped inner length, then drains the last
// product: one multiply-accumulate per cycle on one read port per store. The result
// register loads once the output is free; bad or empty requests skip the reads.
// Synchronous reset clears control and output valid and restores the size and shift registers.
// Matrix stores are not cleared and read undefined until written.
module int8_matmul_requant_clamp_unit #(
  parameter int DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         mode,
  input  logic [3:0]                         row,
  input  logic [3:0]                         col,
  input  logic [7:0]                         elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic signed [imrc_pkg::SUM_W-1:0]  dot_sum,
  output logic                               range_error,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [imrc_pkg::REG_W-1:0]         cfg_data
);

  import imrc_pkg::*;

  cmd_t    cmd;
  status_t status;

  imrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  imrc_dp #(
    .DIM(DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .row         (row),
    .col         (col),
    .elem_value  (elem_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .dot_sum     (dot_sum),
    .range_error (range_error)
  );

endmodule
